// ===== hw/rtl/ocrm_pkg.sv =====
// ============================================================================
// ocrm_pkg
// Shared widths, codes, state encoding and the command and status bundles
// that join the controller and the datapath of the closing-rate monitor.
// ============================================================================
package ocrm_pkg;

  localparam int unsigned DATA_W = 32;
  localparam int unsigned MAG_W  = 33;
  localparam int unsigned PROD_W = 66;
  localparam int unsigned ACC_W  = 68;
  localparam int unsigned ROOT_W = 34;
  localparam int unsigned SUM_W  = 40;
  localparam int unsigned DVD_W  = 72;
  localparam int unsigned DVS_W  = 40;
  localparam int unsigned CNT_W  = 7;
  localparam int unsigned OBJ_W  = 3;
  localparam int unsigned WL_W   = 5;

  localparam logic [WL_W-1:0]  WL_RESET = 5'd10;
  localparam logic [CNT_W-1:0] ITER_VEL = 7'd49;
  localparam logic [CNT_W-1:0] ITER_AVG = 7'd40;
  localparam logic [CNT_W-1:0] ITER_FAC = 7'd72;

  localparam logic [DATA_W-1:0] S32_MAX = 32'h7FFF_FFFF;
  localparam logic [DATA_W-1:0] S32_MIN = 32'h8000_0000;
  localparam logic [DATA_W-1:0] U32_MAX = 32'hFFFF_FFFF;

  typedef enum logic [1:0] {
    ACT_OBSTACLE = 2'd0,
    ACT_VEHICLE  = 2'd1,
    ACT_EVALUATE = 2'd2,
    ACT_NONE     = 2'd3
  } action_t;

  typedef enum logic [4:0] {
    ST_IDLE,
    ST_VEL_LOAD,
    ST_VEL_DIV,
    ST_VEL_WAIT,
    ST_DROP_CHK,
    ST_DROP_RD,
    ST_DROP_SUB,
    ST_PUSH,
    ST_AVG_DIV,
    ST_AVG_WAIT,
    ST_EV_LOAD,
    ST_EV_MUL,
    ST_EV_ACC1,
    ST_EV_ACC2,
    ST_SQRT,
    ST_SQRT_WAIT,
    ST_EV_DEC,
    ST_FDIV_WAIT,
    ST_OUT
  } state_t;

  typedef struct packed {
    logic             vel_load;
    logic             vel_zero;
    logic             vel_start;
    logic             vel_take;
    logic             drop_rd;
    logic             drop_sub;
    logic             push;
    logic             avg_start;
    logic             avg_take;
    logic             ev_load;
    logic             ev_mul;
    logic             ev_acc1;
    logic             ev_acc2;
    logic             sqrt_start;
    logic             fac_zero;
    logic             fac_max;
    logic             fac_start;
    logic             fac_take;
    logic             out_load;
    logic             out_last;
    logic [1:0]       axis;
    logic [OBJ_W-1:0] obj;
  } cmd_t;

  typedef struct packed {
    logic dt_zero;
    logic div_busy;
    logic sqrt_busy;
    logic drop_needed;
    logic d_nonneg;
    logic root_zero;
    logic out_free;
  } status_t;

endpackage

// ===== hw/rtl/ocrm_if.sv =====
// ============================================================================
// ocrm channel interfaces
// Request, result and configuration channels with valid/ready handshake.
// ============================================================================
interface ocrm_in_if;
  logic               valid;
  logic               ready;
  logic [1:0]         action;
  logic               object_index;
  logic signed [31:0] pos_x;
  logic signed [31:0] pos_y;
  logic signed [31:0] pos_z;
  logic signed [31:0] vel_x;
  logic signed [31:0] vel_y;
  logic signed [31:0] vel_z;
  logic [31:0]        time_step;

  modport source (output valid, action, object_index, pos_x, pos_y, pos_z,
                  vel_x, vel_y, vel_z, time_step, input ready);
  modport sink (input valid, action, object_index, pos_x, pos_y, pos_z,
                vel_x, vel_y, vel_z, time_step, output ready);
endinterface

interface ocrm_out_if;
  logic        valid;
  logic        ready;
  logic        result_object;
  logic [31:0] closing_factor;
  logic        last_result;

  modport source (output valid, result_object, closing_factor, last_result,
                  input ready);
  modport sink (input valid, result_object, closing_factor, last_result,
                output ready);
endinterface

interface ocrm_cfg_if;
  logic       valid;
  logic       ready;
  logic [4:0] data;

  modport source (output valid, data, input ready);
  modport sink (input valid, data, output ready);
endinterface

// ===== hw/rtl/obstacle_closing_rate_monitor_core.sv =====
// ============================================================================
// obstacle_closing_rate_monitor_core
// Obstacle velocity smoothing and vehicle closing-rate evaluation.
// ============================================================================
// Vehicle request: stored on acceptance. Obstacle sample: per-axis velocity divide
//   (skipped for a zero time step), oldest entries dropped while the window is full,
//   push, averaging divide. Evaluate, per obstacle: multiply-accumulate, square root,
//   decide, divide if needed, output; output stalls hold it.
// One request at a time; results wait in an output register.
// Reset (rst_n, synchronous) clears all state but the history memory and working registers; window 10.
module obstacle_closing_rate_monitor_core #(
  parameter int unsigned NUM_OBSTACLES = 2,
  parameter int unsigned MAX_WINDOW    = 16
) (
  input  logic      clk,
  input  logic      rst_n,
  ocrm_in_if.sink   in_ch,
  ocrm_out_if.source out_ch,
  ocrm_cfg_if.sink  cfg_ch
);

  ocrm_pkg::cmd_t    cmd;
  ocrm_pkg::status_t status;
  logic              in_ready;

  assign in_ch.ready  = in_ready;
  assign cfg_ch.ready = 1'b1;

  ocrm_ctrl #(
    .NUM_OBSTACLES (NUM_OBSTACLES)
  ) u_ctrl (
    .clk             (clk),
    .rst_n           (rst_n),
    .in_valid        (in_ch.valid),
    .in_action       (in_ch.action),
    .in_object_index (in_ch.object_index),
    .in_ready        (in_ready),
    .status          (status),
    .cmd             (cmd)
  );

  ocrm_dp #(
    .NUM_OBSTACLES (NUM_OBSTACLES),
    .MAX_WINDOW    (MAX_WINDOW)
  ) u_dp (
    .clk                (clk),
    .rst_n              (rst_n),
    .accept             (in_ch.valid && in_ready),
    .in_action          (in_ch.action),
    .in_pos_x           (in_ch.pos_x),
    .in_pos_y           (in_ch.pos_y),
    .in_pos_z           (in_ch.pos_z),
    .in_vel_x           (in_ch.vel_x),
    .in_vel_y           (in_ch.vel_y),
    .in_vel_z           (in_ch.vel_z),
    .in_time_step       (in_ch.time_step),
    .cfg_we             (cfg_ch.valid),
    .cfg_data           (cfg_ch.data),
    .cmd                (cmd),
    .status             (status),
    .out_valid          (out_ch.valid),
    .out_ready          (out_ch.ready),
    .out_result_object  (out_ch.result_object),
    .out_closing_factor (out_ch.closing_factor),
    .out_last_result    (out_ch.last_result)
  );

endmodule

// ===== hw/rtl/ocrm_div.sv =====
// ============================================================================
// ocrm_div
// Shared restoring divider, one quotient bit per cycle, left-aligned dividend.
// ============================================================================
module ocrm_div (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        start,
  input  logic [ocrm_pkg::CNT_W-1:0]  iter,
  input  logic [ocrm_pkg::DVD_W-1:0]  dividend,
  input  logic [ocrm_pkg::DVS_W-1:0]  divisor,
  output logic                        busy,
  output logic [ocrm_pkg::DVD_W-1:0]  quotient
);

  localparam int unsigned DW = ocrm_pkg::DVD_W;
  localparam int unsigned SW = ocrm_pkg::DVS_W;

  logic                        busy_r, busy_nxt;
  logic [ocrm_pkg::CNT_W-1:0]  cnt_r, cnt_nxt;
  logic [DW-1:0]               dvd_r, dvd_nxt;
  logic [SW-1:0]               dvs_r, dvs_nxt;
  logic [SW:0]                 rem_r, rem_nxt;
  logic [SW:0]                 shifted;
  logic                        fits;

  always_comb begin
    shifted  = {rem_r[SW-1:0], dvd_r[DW-1]};
    fits     = (shifted >= {1'b0, dvs_r});
    busy_nxt = busy_r;
    cnt_nxt  = cnt_r;
    dvd_nxt  = dvd_r;
    dvs_nxt  = dvs_r;
    rem_nxt  = rem_r;
    if (start) begin
      busy_nxt = 1'b1;
      cnt_nxt  = iter;
      dvd_nxt  = dividend;
      dvs_nxt  = divisor;
      rem_nxt  = '0;
    end else if (busy_r) begin
      rem_nxt = fits ? (shifted - {1'b0, dvs_r}) : shifted;
      dvd_nxt = {dvd_r[DW-2:0], fits};
      cnt_nxt = cnt_r - 1'b1;
      if (cnt_r == ocrm_pkg::CNT_W'(1)) begin
        busy_nxt = 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      busy_r <= busy_nxt;
      cnt_r  <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    dvd_r <= dvd_nxt;
    dvs_r <= dvs_nxt;
    rem_r <= rem_nxt;
  end

  assign busy     = busy_r;
  assign quotient = dvd_r;

  a_start_busy: assert property (@(posedge clk) disable iff (!rst_n)
    start |=> busy_r) else $error("divider did not start");
  a_cnt_live: assert property (@(posedge clk) disable iff (!rst_n)
    busy_r |-> (cnt_r != '0)) else $error("divider busy with zero count");
  a_busy_done: assert property (@(posedge clk) disable iff (!rst_n)
    (busy_r && (cnt_r == ocrm_pkg::CNT_W'(1)) && !start) |=> !busy_r)
    else $error("divider ran past its count");

endmodule

// ===== hw/rtl/ocrm_sqrt.sv =====
// ============================================================================
// ocrm_sqrt
// Digit-by-digit integer square root, two radicand bits per cycle.
// ============================================================================
module ocrm_sqrt (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        start,
  input  logic [ocrm_pkg::ACC_W-1:0]  radicand,
  output logic                        busy,
  output logic [ocrm_pkg::ROOT_W-1:0] root
);

  localparam int unsigned RW = ocrm_pkg::ROOT_W;
  localparam int unsigned XW = ocrm_pkg::ACC_W;
  localparam int unsigned CW = $clog2(RW + 1);

  logic            busy_r, busy_nxt;
  logic [CW-1:0]   cnt_r, cnt_nxt;
  logic [XW-1:0]   x_r, x_nxt;
  logic [RW+2:0]   rem_r, rem_nxt;
  logic [RW-1:0]   root_r, root_nxt;
  logic [RW+2:0]   shifted;
  logic [RW+2:0]   trial;
  logic            fits;

  always_comb begin
    shifted  = {rem_r[RW:0], x_r[XW-1:XW-2]};
    trial    = {1'b0, root_r, 2'b01};
    fits     = (shifted >= trial);
    busy_nxt = busy_r;
    cnt_nxt  = cnt_r;
    x_nxt    = x_r;
    rem_nxt  = rem_r;
    root_nxt = root_r;
    if (start) begin
      busy_nxt = 1'b1;
      cnt_nxt  = CW'(RW);
      x_nxt    = radicand;
      rem_nxt  = '0;
      root_nxt = '0;
    end else if (busy_r) begin
      rem_nxt  = fits ? (shifted - trial) : shifted;
      root_nxt = {root_r[RW-2:0], fits};
      x_nxt    = {x_r[XW-3:0], 2'b00};
      cnt_nxt  = cnt_r - 1'b1;
      if (cnt_r == CW'(1)) begin
        busy_nxt = 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      busy_r <= busy_nxt;
      cnt_r  <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    x_r    <= x_nxt;
    rem_r  <= rem_nxt;
    root_r <= root_nxt;
  end

  assign busy = busy_r;
  assign root = root_r;

endmodule

// ===== hw/rtl/ocrm_dp.sv =====
// ============================================================================
// ocrm_dp
// Datapath: obstacle and vehicle state, velocity history memory, shared
// divider and square root, multiply-accumulate and the result register.
// ============================================================================
module ocrm_dp #(
  parameter int unsigned NUM_OBSTACLES = 2,
  parameter int unsigned MAX_WINDOW    = 16
) (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       accept,
  input  logic [1:0]                 in_action,
  input  logic signed [31:0]         in_pos_x,
  input  logic signed [31:0]         in_pos_y,
  input  logic signed [31:0]         in_pos_z,
  input  logic signed [31:0]         in_vel_x,
  input  logic signed [31:0]         in_vel_y,
  input  logic signed [31:0]         in_vel_z,
  input  logic [31:0]                in_time_step,
  input  logic                       cfg_we,
  input  logic [ocrm_pkg::WL_W-1:0]  cfg_data,
  input  ocrm_pkg::cmd_t             cmd,
  output ocrm_pkg::status_t          status,
  output logic                       out_valid,
  input  logic                       out_ready,
  output logic                       out_result_object,
  output logic [31:0]                out_closing_factor,
  output logic                       out_last_result
);

  localparam int unsigned OW    = (NUM_OBSTACLES > 1) ? $clog2(NUM_OBSTACLES) : 1;
  localparam int unsigned HW    = (MAX_WINDOW > 1) ? $clog2(MAX_WINDOW) : 1;
  localparam int unsigned FW    = $clog2(MAX_WINDOW + 1);
  localparam int unsigned TW    = HW + 2;
  localparam int unsigned DEPTH = NUM_OBSTACLES * MAX_WINDOW;
  localparam int unsigned AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned DW    = ocrm_pkg::DATA_W;
  localparam int unsigned SUMW  = ocrm_pkg::SUM_W;

  logic [ocrm_pkg::WL_W-1:0] wl_r, wl_nxt;

  logic signed [DW-1:0] in_pos [3];
  logic signed [DW-1:0] in_vel [3];

  logic signed [DW-1:0] lat_pos_r [3];
  logic signed [DW-1:0] lat_pos_nxt [3];
  logic [DW-1:0]        lat_dt_r, lat_dt_nxt;

  logic signed [DW-1:0] veh_pos_r [3];
  logic signed [DW-1:0] veh_pos_nxt [3];
  logic signed [DW-1:0] veh_vel_r [3];
  logic signed [DW-1:0] veh_vel_nxt [3];

  logic signed [DW-1:0]   pos_r [NUM_OBSTACLES][3];
  logic signed [DW-1:0]   pos_nxt [NUM_OBSTACLES][3];
  logic signed [DW-1:0]   avg_r [NUM_OBSTACLES][3];
  logic signed [DW-1:0]   avg_nxt [NUM_OBSTACLES][3];
  logic signed [SUMW-1:0] sum_r [NUM_OBSTACLES][3];
  logic signed [SUMW-1:0] sum_nxt [NUM_OBSTACLES][3];
  logic [FW-1:0]          fill_r [NUM_OBSTACLES];
  logic [FW-1:0]          fill_nxt [NUM_OBSTACLES];
  logic [HW-1:0]          head_r [NUM_OBSTACLES];
  logic [HW-1:0]          head_nxt [NUM_OBSTACLES];

  logic signed [DW-1:0] vel_r [3];
  logic signed [DW-1:0] vel_nxt [3];

  logic [ocrm_pkg::MAG_W-1:0]  dmag_r, dmag_nxt;
  logic                        dneg_r, dneg_nxt;
  logic                        dnz_r, dnz_nxt;

  logic [ocrm_pkg::MAG_W-1:0]  emag_r, emag_nxt;
  logic [ocrm_pkg::MAG_W-1:0]  rmag_r, rmag_nxt;
  logic                        erneg_r, erneg_nxt;
  logic [ocrm_pkg::PROD_W-1:0] prod_r, prod_nxt;
  logic [ocrm_pkg::ACC_W-1:0]  pacc_r, pacc_nxt;
  logic [ocrm_pkg::ACC_W-1:0]  nacc_r, nacc_nxt;
  logic [ocrm_pkg::ACC_W-1:0]  sq_r, sq_nxt;
  logic [DW-1:0]               fac_r, fac_nxt;

  logic        out_valid_r, out_valid_nxt;
  logic        out_obj_r, out_obj_nxt;
  logic [DW-1:0] out_fac_r, out_fac_nxt;
  logic        out_last_r, out_last_nxt;

  logic [3*DW-1:0] hist_mem [DEPTH];
  logic [3*DW-1:0] rdata_r;

  logic [OW-1:0]   oi;
  logic [1:0]      ax;
  logic [6:0]      wclamp;
  logic [TW-1:0]   old_sum;
  logic [HW-1:0]   old_slot;
  logic [AW-1:0]   addr_old;
  logic [AW-1:0]   addr_head;

  logic signed [ocrm_pkg::MAG_W-1:0] diff, e_val, r_val;
  logic signed [SUMW-1:0]            sum_sel;
  logic [SUMW-1:0]                   sum_mag;
  logic [DW-1:0]                     q32;
  logic [ocrm_pkg::MAG_W-1:0]        mul_b;
  logic [ocrm_pkg::ACC_W-1:0]        num;

  logic                          div_start;
  logic [ocrm_pkg::CNT_W-1:0]    div_iter;
  logic [ocrm_pkg::DVD_W-1:0]    div_dvd;
  logic [ocrm_pkg::DVS_W-1:0]    div_dvs;
  logic                          div_busy;
  logic [ocrm_pkg::DVD_W-1:0]    div_q;
  logic                          sqrt_busy;
  logic [ocrm_pkg::ROOT_W-1:0]   root;

  assign in_pos[0] = in_pos_x;
  assign in_pos[1] = in_pos_y;
  assign in_pos[2] = in_pos_z;
  assign in_vel[0] = in_vel_x;
  assign in_vel[1] = in_vel_y;
  assign in_vel[2] = in_vel_z;

  assign oi = cmd.obj[OW-1:0];
  assign ax = cmd.axis;

  always_comb begin
    if (wl_r == '0) begin
      wclamp = 7'd1;
    end else if (int'(wl_r) > int'(MAX_WINDOW)) begin
      wclamp = 7'(MAX_WINDOW);
    end else begin
      wclamp = 7'(wl_r);
    end
    old_sum = TW'(head_r[oi]) + TW'(MAX_WINDOW) - TW'(fill_r[oi]);
    if (old_sum >= TW'(MAX_WINDOW)) begin
      old_sum = old_sum - TW'(MAX_WINDOW);
    end
    old_slot  = old_sum[HW-1:0];
    addr_old  = AW'(int'(oi) * int'(MAX_WINDOW) + int'(old_slot));
    addr_head = AW'(int'(oi) * int'(MAX_WINDOW) + int'(head_r[oi]));
  end

  always_comb begin
    diff    = {lat_pos_r[ax][DW-1], lat_pos_r[ax]} - {pos_r[oi][ax][DW-1], pos_r[oi][ax]};
    e_val   = {veh_pos_r[ax][DW-1], veh_pos_r[ax]} - {pos_r[oi][ax][DW-1], pos_r[oi][ax]};
    r_val   = {veh_vel_r[ax][DW-1], veh_vel_r[ax]} - {avg_r[oi][ax][DW-1], avg_r[oi][ax]};
    sum_sel = sum_r[oi][ax];
    sum_mag = sum_sel[SUMW-1] ? SUMW'(-sum_sel) : SUMW'(sum_sel);
    q32     = div_q[DW-1:0];
    mul_b   = cmd.ev_acc1 ? emag_r : rmag_r;
    num     = nacc_r - pacc_r;

    div_start = cmd.vel_start | cmd.avg_start | cmd.fac_start;
    if (cmd.vel_start) begin
      div_iter = ocrm_pkg::ITER_VEL;
      div_dvd  = {dmag_r, 39'b0};
      div_dvs  = ocrm_pkg::DVS_W'(lat_dt_r);
    end else if (cmd.avg_start) begin
      div_iter = ocrm_pkg::ITER_AVG;
      div_dvd  = {sum_mag, 32'b0};
      div_dvs  = ocrm_pkg::DVS_W'(fill_r[oi]);
    end else begin
      div_iter = ocrm_pkg::ITER_FAC;
      div_dvd  = ocrm_pkg::DVD_W'(num);
      div_dvs  = ocrm_pkg::DVS_W'(root);
    end
  end

  always_comb begin
    wl_nxt      = wl_r;
    lat_pos_nxt = lat_pos_r;
    lat_dt_nxt  = lat_dt_r;
    veh_pos_nxt = veh_pos_r;
    veh_vel_nxt = veh_vel_r;
    pos_nxt     = pos_r;
    avg_nxt     = avg_r;
    sum_nxt     = sum_r;
    fill_nxt    = fill_r;
    head_nxt    = head_r;
    vel_nxt     = vel_r;
    dmag_nxt    = dmag_r;
    dneg_nxt    = dneg_r;
    dnz_nxt     = dnz_r;
    emag_nxt    = emag_r;
    rmag_nxt    = rmag_r;
    erneg_nxt   = erneg_r;
    prod_nxt    = prod_r;
    pacc_nxt    = pacc_r;
    nacc_nxt    = nacc_r;
    sq_nxt      = sq_r;
    fac_nxt     = fac_r;
    out_valid_nxt = out_valid_r;
    out_obj_nxt   = out_obj_r;
    out_fac_nxt   = out_fac_r;
    out_last_nxt  = out_last_r;

    if (cfg_we) begin
      wl_nxt = cfg_data;
    end
    if (accept) begin
      lat_pos_nxt = in_pos;
      lat_dt_nxt  = in_time_step;
      if (in_action == ocrm_pkg::ACT_VEHICLE) begin
        veh_pos_nxt = in_pos;
        veh_vel_nxt = in_vel;
      end
    end

    if (cmd.vel_load) begin
      dneg_nxt         = diff[ocrm_pkg::MAG_W-1];
      dmag_nxt         = diff[ocrm_pkg::MAG_W-1] ? ocrm_pkg::MAG_W'(-diff)
                                                 : ocrm_pkg::MAG_W'(diff);
      dnz_nxt          = (diff != '0);
      pos_nxt[oi][ax]  = lat_pos_r[ax];
    end
    if (cmd.vel_zero) begin
      if (!dnz_r) begin
        vel_nxt[ax] = '0;
      end else if (dneg_r) begin
        vel_nxt[ax] = ocrm_pkg::S32_MIN;
      end else begin
        vel_nxt[ax] = ocrm_pkg::S32_MAX;
      end
    end
    if (cmd.vel_take) begin
      if (dneg_r) begin
        vel_nxt[ax] = (div_q > ocrm_pkg::DVD_W'(ocrm_pkg::S32_MIN)) ? ocrm_pkg::S32_MIN
                                                                    : DW'(-q32);
      end else begin
        vel_nxt[ax] = (div_q > ocrm_pkg::DVD_W'(ocrm_pkg::S32_MAX)) ? ocrm_pkg::S32_MAX
                                                                    : q32;
      end
    end
    if (cmd.drop_sub) begin
      for (int a = 0; a < 3; a++) begin
        sum_nxt[oi][a] = sum_r[oi][a] - {{(SUMW-DW){rdata_r[a*DW+DW-1]}},
                                         rdata_r[a*DW +: DW]};
      end
      fill_nxt[oi] = fill_r[oi] - 1'b1;
    end
    if (cmd.push) begin
      for (int a = 0; a < 3; a++) begin
        sum_nxt[oi][a] = sum_r[oi][a] + {{(SUMW-DW){vel_r[a][DW-1]}}, vel_r[a]};
      end
      head_nxt[oi] = (int'(head_r[oi]) == int'(MAX_WINDOW) - 1) ? '0
                                                               : head_r[oi] + 1'b1;
      fill_nxt[oi] = fill_r[oi] + 1'b1;
    end
    if (cmd.avg_take) begin
      avg_nxt[oi][ax] = sum_sel[SUMW-1] ? DW'(-q32) : q32;
    end

    if (cmd.ev_load) begin
      if (ax == 2'd0) begin
        pacc_nxt = '0;
        nacc_nxt = '0;
        sq_nxt   = '0;
      end
      emag_nxt  = e_val[ocrm_pkg::MAG_W-1] ? ocrm_pkg::MAG_W'(-e_val)
                                           : ocrm_pkg::MAG_W'(e_val);
      rmag_nxt  = r_val[ocrm_pkg::MAG_W-1] ? ocrm_pkg::MAG_W'(-r_val)
                                           : ocrm_pkg::MAG_W'(r_val);
      erneg_nxt = e_val[ocrm_pkg::MAG_W-1] ^ r_val[ocrm_pkg::MAG_W-1];
    end
    if (cmd.ev_mul || cmd.ev_acc1) begin
      prod_nxt = emag_r * mul_b;
    end
    if (cmd.ev_acc1) begin
      if (erneg_r) begin
        nacc_nxt = nacc_r + ocrm_pkg::ACC_W'(prod_r);
      end else begin
        pacc_nxt = pacc_r + ocrm_pkg::ACC_W'(prod_r);
      end
    end
    if (cmd.ev_acc2) begin
      sq_nxt = sq_r + ocrm_pkg::ACC_W'(prod_r);
    end
    if (cmd.fac_zero) begin
      fac_nxt = '0;
    end
    if (cmd.fac_max) begin
      fac_nxt = ocrm_pkg::U32_MAX;
    end
    if (cmd.fac_take) begin
      fac_nxt = (div_q[ocrm_pkg::DVD_W-1:DW] != '0) ? ocrm_pkg::U32_MAX : q32;
    end

    if (cmd.out_load) begin
      out_valid_nxt = 1'b1;
      out_obj_nxt   = cmd.obj[0];
      out_fac_nxt   = fac_r;
      out_last_nxt  = cmd.out_last;
    end else if (out_ready) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wl_r        <= ocrm_pkg::WL_RESET;
      out_valid_r <= 1'b0;
      for (int a = 0; a < 3; a++) begin
        veh_pos_r[a] <= '0;
        veh_vel_r[a] <= '0;
      end
      for (int j = 0; j < int'(NUM_OBSTACLES); j++) begin
        fill_r[j] <= '0;
        head_r[j] <= '0;
        for (int a = 0; a < 3; a++) begin
          pos_r[j][a] <= '0;
          avg_r[j][a] <= '0;
          sum_r[j][a] <= '0;
        end
      end
    end else begin
      wl_r        <= wl_nxt;
      out_valid_r <= out_valid_nxt;
      veh_pos_r   <= veh_pos_nxt;
      veh_vel_r   <= veh_vel_nxt;
      fill_r      <= fill_nxt;
      head_r      <= head_nxt;
      pos_r       <= pos_nxt;
      avg_r       <= avg_nxt;
      sum_r       <= sum_nxt;
    end
  end

  always_ff @(posedge clk) begin
    lat_pos_r  <= lat_pos_nxt;
    lat_dt_r   <= lat_dt_nxt;
    vel_r      <= vel_nxt;
    dmag_r     <= dmag_nxt;
    dneg_r     <= dneg_nxt;
    dnz_r      <= dnz_nxt;
    emag_r     <= emag_nxt;
    rmag_r     <= rmag_nxt;
    erneg_r    <= erneg_nxt;
    prod_r     <= prod_nxt;
    pacc_r     <= pacc_nxt;
    nacc_r     <= nacc_nxt;
    sq_r       <= sq_nxt;
    fac_r      <= fac_nxt;
    out_obj_r  <= out_obj_nxt;
    out_fac_r  <= out_fac_nxt;
    out_last_r <= out_last_nxt;
  end

  always_ff @(posedge clk) begin
    if (cmd.push) begin
      hist_mem[addr_head] <= {vel_r[2], vel_r[1], vel_r[0]};
    end
    if (cmd.drop_rd) begin
      rdata_r <= hist_mem[addr_old];
    end
  end

  ocrm_div u_div (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (div_start),
    .iter     (div_iter),
    .dividend (div_dvd),
    .divisor  (div_dvs),
    .busy     (div_busy),
    .quotient (div_q)
  );

  ocrm_sqrt u_sqrt (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (cmd.sqrt_start),
    .radicand (sq_r),
    .busy     (sqrt_busy),
    .root     (root)
  );

  always_comb begin
    status.dt_zero     = (lat_dt_r == '0);
    status.div_busy    = div_busy;
    status.sqrt_busy   = sqrt_busy;
    status.drop_needed = (7'(fill_r[oi]) >= wclamp);
    status.d_nonneg    = (nacc_r <= pacc_r);
    status.root_zero   = (root == '0);
    status.out_free    = !out_valid_r || out_ready;
  end

  assign out_valid          = out_valid_r;
  assign out_result_object  = out_obj_r;
  assign out_closing_factor = out_fac_r;
  assign out_last_result    = out_last_r;

endmodule

// ===== hw/rtl/ocrm_ctrl.sv =====
// ============================================================================
// ocrm_ctrl
// Controller: decodes requests and sequences the datapath per axis and
// per obstacle.
// ============================================================================
module ocrm_ctrl #(
  parameter int unsigned NUM_OBSTACLES = 2
) (
  input  logic                    clk,
  input  logic                    rst_n,
  input  logic                    in_valid,
  input  logic [1:0]              in_action,
  input  logic                    in_object_index,
  output logic                    in_ready,
  input  ocrm_pkg::status_t       status,
  output ocrm_pkg::cmd_t          cmd
);

  localparam int unsigned EVAL_COUNT = (NUM_OBSTACLES < 2) ? NUM_OBSTACLES : 2;
  localparam logic [ocrm_pkg::OBJ_W-1:0] LAST_OBJ = ocrm_pkg::OBJ_W'(EVAL_COUNT - 1);

  ocrm_pkg::state_t              state_r, state_nxt;
  logic [1:0]                    axis_r, axis_nxt;
  logic [ocrm_pkg::OBJ_W-1:0]    obj_r, obj_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ocrm_pkg::ST_IDLE;
      axis_r  <= '0;
      obj_r   <= '0;
    end else begin
      state_r <= state_nxt;
      axis_r  <= axis_nxt;
      obj_r   <= obj_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    axis_nxt  = axis_r;
    obj_nxt   = obj_r;
    in_ready  = 1'b0;
    cmd       = '0;
    cmd.axis  = axis_r;
    cmd.obj   = obj_r;
    unique case (state_r)
      ocrm_pkg::ST_IDLE: begin
        in_ready = 1'b1;
        axis_nxt = '0;
        if (in_valid) begin
          unique case (ocrm_pkg::action_t'(in_action))
            ocrm_pkg::ACT_OBSTACLE: begin
              if (int'(in_object_index) < int'(NUM_OBSTACLES)) begin
                obj_nxt   = ocrm_pkg::OBJ_W'(in_object_index);
                state_nxt = ocrm_pkg::ST_VEL_LOAD;
              end
            end
            ocrm_pkg::ACT_EVALUATE: begin
              obj_nxt   = '0;
              state_nxt = ocrm_pkg::ST_EV_LOAD;
            end
            default: begin
            end
          endcase
        end
      end
      ocrm_pkg::ST_VEL_LOAD: begin
        cmd.vel_load = 1'b1;
        state_nxt    = ocrm_pkg::ST_VEL_DIV;
      end
      ocrm_pkg::ST_VEL_DIV: begin
        if (status.dt_zero) begin
          cmd.vel_zero = 1'b1;
          axis_nxt     = (axis_r == 2'd2) ? 2'd0 : axis_r + 2'd1;
          state_nxt    = (axis_r == 2'd2) ? ocrm_pkg::ST_DROP_CHK : ocrm_pkg::ST_VEL_LOAD;
        end else begin
          cmd.vel_start = 1'b1;
          state_nxt     = ocrm_pkg::ST_VEL_WAIT;
        end
      end
      ocrm_pkg::ST_VEL_WAIT: begin
        if (!status.div_busy) begin
          cmd.vel_take = 1'b1;
          axis_nxt     = (axis_r == 2'd2) ? 2'd0 : axis_r + 2'd1;
          state_nxt    = (axis_r == 2'd2) ? ocrm_pkg::ST_DROP_CHK : ocrm_pkg::ST_VEL_LOAD;
        end
      end
      ocrm_pkg::ST_DROP_CHK: begin
        state_nxt = status.drop_needed ? ocrm_pkg::ST_DROP_RD : ocrm_pkg::ST_PUSH;
      end
      ocrm_pkg::ST_DROP_RD: begin
        cmd.drop_rd = 1'b1;
        state_nxt   = ocrm_pkg::ST_DROP_SUB;
      end
      ocrm_pkg::ST_DROP_SUB: begin
        cmd.drop_sub = 1'b1;
        state_nxt    = ocrm_pkg::ST_DROP_CHK;
      end
      ocrm_pkg::ST_PUSH: begin
        cmd.push  = 1'b1;
        axis_nxt  = '0;
        state_nxt = ocrm_pkg::ST_AVG_DIV;
      end
      ocrm_pkg::ST_AVG_DIV: begin
        cmd.avg_start = 1'b1;
        state_nxt     = ocrm_pkg::ST_AVG_WAIT;
      end
      ocrm_pkg::ST_AVG_WAIT: begin
        if (!status.div_busy) begin
          cmd.avg_take = 1'b1;
          axis_nxt     = (axis_r == 2'd2) ? 2'd0 : axis_r + 2'd1;
          state_nxt    = (axis_r == 2'd2) ? ocrm_pkg::ST_IDLE : ocrm_pkg::ST_AVG_DIV;
        end
      end
      ocrm_pkg::ST_EV_LOAD: begin
        cmd.ev_load = 1'b1;
        state_nxt   = ocrm_pkg::ST_EV_MUL;
      end
      ocrm_pkg::ST_EV_MUL: begin
        cmd.ev_mul = 1'b1;
        state_nxt  = ocrm_pkg::ST_EV_ACC1;
      end
      ocrm_pkg::ST_EV_ACC1: begin
        cmd.ev_acc1 = 1'b1;
        state_nxt   = ocrm_pkg::ST_EV_ACC2;
      end
      ocrm_pkg::ST_EV_ACC2: begin
        cmd.ev_acc2 = 1'b1;
        axis_nxt    = (axis_r == 2'd2) ? 2'd0 : axis_r + 2'd1;
        state_nxt   = (axis_r == 2'd2) ? ocrm_pkg::ST_SQRT : ocrm_pkg::ST_EV_LOAD;
      end
      ocrm_pkg::ST_SQRT: begin
        cmd.sqrt_start = 1'b1;
        state_nxt      = ocrm_pkg::ST_SQRT_WAIT;
      end
      ocrm_pkg::ST_SQRT_WAIT: begin
        if (!status.sqrt_busy) begin
          state_nxt = ocrm_pkg::ST_EV_DEC;
        end
      end
      ocrm_pkg::ST_EV_DEC: begin
        if (status.d_nonneg) begin
          cmd.fac_zero = 1'b1;
          state_nxt    = ocrm_pkg::ST_OUT;
        end else if (status.root_zero) begin
          cmd.fac_max = 1'b1;
          state_nxt   = ocrm_pkg::ST_OUT;
        end else begin
          cmd.fac_start = 1'b1;
          state_nxt     = ocrm_pkg::ST_FDIV_WAIT;
        end
      end
      ocrm_pkg::ST_FDIV_WAIT: begin
        if (!status.div_busy) begin
          cmd.fac_take = 1'b1;
          state_nxt    = ocrm_pkg::ST_OUT;
        end
      end
      ocrm_pkg::ST_OUT: begin
        if (status.out_free) begin
          cmd.out_load = 1'b1;
          cmd.out_last = (obj_r == LAST_OBJ);
          axis_nxt     = '0;
          if (obj_r == LAST_OBJ) begin
            state_nxt = ocrm_pkg::ST_IDLE;
          end else begin
            obj_nxt   = obj_r + 1'b1;
            state_nxt = ocrm_pkg::ST_EV_LOAD;
          end
        end
      end
      default: begin
        state_nxt = ocrm_pkg::ST_IDLE;
      end
    endcase
  end

  a_out_free: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.out_load |-> status.out_free) else $error("result loaded over pending result");
  a_fdiv_out: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ocrm_pkg::ST_FDIV_WAIT && !status.div_busy)
      |=> (state_r == ocrm_pkg::ST_OUT)) else $error("factor not forwarded");
  a_obj_range: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r != ocrm_pkg::ST_IDLE) |-> (int'(obj_r) < int'(NUM_OBSTACLES)))
    else $error("obstacle index out of range");

endmodule
